// File: rtl/core/ppf_pkg.sv
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types, constants and helper functions for the portal packet
// prefilter: verdict reason codes, protocol numbers and address checks.
// ----------------------------------------------------------------------------
`default_nettype none

package ppf_pkg;

  // verdict reason codes
  typedef enum logic [3:0] {
    RSN_DISABLED  = 4'd0,
    RSN_NOT_IPV4  = 4'd1,
    RSN_OTHER     = 4'd2,
    RSN_SPECIAL   = 4'd3,
    RSN_TCP_CTL   = 4'd4,
    RSN_NOT_GET   = 4'd5,
    RSN_DNS_DHCP  = 4'd6,
    RSN_CANDIDATE = 4'd7,
    RSN_TRUNC     = 4'd8
  } reason_t;

  // configuration register indexes
  localparam logic REG_CONFIG_READY = 1'b0;
  localparam logic REG_BYPASS_ALL   = 1'b1;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // ip protocol numbers and ports
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] PORT_DNS   = 16'd53;
  localparam logic [15:0] PORT_DHCP  = 16'd67;
  localparam logic [2:0]  MATCH_LEN  = 3'd4;

  // byte positions in the ip header
  localparam logic [15:0] POS_TLEN_HI  = 16'd2;
  localparam logic [15:0] POS_TLEN_LO  = 16'd3;
  localparam logic [15:0] POS_PROTO    = 16'd9;
  localparam logic [15:0] POS_SRC_LO   = 16'd12;
  localparam logic [15:0] POS_SRC_HI   = 16'd15;
  localparam logic [15:0] POS_DST_LO   = 16'd16;
  localparam logic [15:0] POS_DST_HI   = 16'd19;
  localparam logic [15:0] MIN_PROTO_CNT = 16'd10;
  localparam logic [15:0] MIN_HDR_CNT   = 16'd20;
  localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;

  // offsets relative to the transport header
  localparam logic [15:0] OFF_PORT_HI = 16'd2;
  localparam logic [15:0] OFF_PORT_LO = 16'd3;
  localparam logic [15:0] OFF_TCP_DO  = 16'd12;
  localparam logic [15:0] OFF_TCP_FLG = 16'd13;
  localparam logic [15:0] OFF_TCP_END = 16'd14;
  localparam logic [15:0] OFF_UDP_END = 16'd4;

  localparam logic [15:0] IDX_MAX = 16'hFFFF;

  // "GET " one character at a time
  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // fold lower-case ascii letters to upper case
  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (b >= 8'h61 && b <= 8'h7A) u = b - 8'd32;
    return u;
  endfunction

  // limited broadcast, loopback, multicast or zero-net
  function automatic logic special_addr(input logic [31:0] a);
    logic s;
    s = (a == 32'hFFFF_FFFF) || (a[31:24] == 8'h7F) ||
        (a[31:28] == 4'hE) || (a[31:24] == 8'h00);
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ppf_if.sv
// ----------------------------------------------------------------------------
// ppf_if
// Valid/ready channel interfaces: packet bytes in, verdicts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       is_ipv4_frame;

  modport source (output valid, data_byte, first_byte, last_byte, is_ipv4_frame,
                  input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, is_ipv4_frame,
                  output ready);
endinterface

interface ppf_out_if;
  logic       valid;
  logic       ready;
  logic       needs_auth;
  logic [3:0] pass_reason;

  modport source (output valid, needs_auth, pass_reason, input ready);
  modport sink   (input valid, needs_auth, pass_reason, output ready);
endinterface

`default_nettype wire

// File: rtl/core/portal_packet_prefilter_top.sv
// ----------------------------------------------------------------------------
// portal_packet_prefilter_top
// Byte-serial IPv4 prefilter: captures header fields per packet and gives a
// pass / authenticate verdict on each packet's last byte.
// ----------------------------------------------------------------------------
// the verdict is registered in the cycle after the last byte is accepted
// throughput: one byte per cycle unless a verdict waits on out_ch.ready;
//   the field capture and verdict logic sit between the byte-position state
//   and the one-entry output register
// reset: synchronous active-low rst_n clears the byte position, the output
//   valid and both configuration bits; no clearing pass
`default_nettype none

module portal_packet_prefilter_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  ppf_in_if.sink                         in_ch,
  ppf_out_if.source                      out_ch,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ppf_pkg::AddrW-1:0] paddr,
  input  wire logic [ppf_pkg::DataW-1:0] pwdata,
  output logic      [ppf_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  // configuration registers
  logic cfg_ready_r, bypass_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ready_r <= 1'b0;
      bypass_r    <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == ppf_pkg::REG_CONFIG_READY) cfg_ready_r <= pwdata[0];
      if (paddr[2] == ppf_pkg::REG_BYPASS_ALL)   bypass_r    <= pwdata[0];
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    if (paddr[2] == ppf_pkg::REG_CONFIG_READY) prdata[0] = cfg_ready_r;
    else                                       prdata[0] = bypass_r;
  end

  // output register and handshake
  logic            out_valid_r, out_auth_r;
  ppf_pkg::reason_t out_reason_r;
  logic            in_acc;

  assign in_ch.ready       = !out_valid_r || out_ch.ready;
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.needs_auth = out_auth_r;
  assign out_ch.pass_reason = out_reason_r;

  // per-packet state
  logic [15:0] idx_r, idx_nxt;
  logic        v4_r, v4_nxt;
  logic [5:0]  ihl_r, ihl_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [5:0]  tcph_r, tcph_nxt;
  logic        ctl_r, ctl_nxt;
  logic [15:0] uport_r, uport_nxt;
  logic [2:0]  gm_r, gm_nxt;

  logic        start;
  logic [15:0] p, cnt, h16;
  logic [7:0]  b;
  logic [15:0] ps16;

  // capture the current byte into the packet fields
  always_comb begin
    b     = in_ch.data_byte;
    start = in_ch.first_byte || (idx_r == '0);
    p     = start ? '0 : idx_r;

    v4_nxt    = start ? in_ch.is_ipv4_frame : v4_r;
    ihl_nxt   = start ? '0 : ihl_r;
    tlen_nxt  = start ? '0 : tlen_r;
    proto_nxt = start ? '0 : proto_r;
    src_nxt   = start ? '0 : src_r;
    dst_nxt   = start ? '0 : dst_r;
    tcph_nxt  = start ? '0 : tcph_r;
    ctl_nxt   = start ? 1'b0 : ctl_r;
    uport_nxt = start ? '0 : uport_r;
    gm_nxt    = start ? '0 : gm_r;

    h16  = {10'd0, ihl_nxt};
    ps16 = h16 + {10'd0, tcph_nxt} + {13'd0, gm_nxt};

    if (p != ppf_pkg::IDX_MAX) begin
      if (p == '0) begin
        ihl_nxt = {b[3:0], 2'b00};
      end else begin
        if (p == ppf_pkg::POS_TLEN_HI) tlen_nxt[15:8] = b;
        if (p == ppf_pkg::POS_TLEN_LO) tlen_nxt[7:0]  = b;
        if (p == ppf_pkg::POS_PROTO)   proto_nxt      = b;
        if (p >= ppf_pkg::POS_SRC_LO && p <= ppf_pkg::POS_SRC_HI)
          src_nxt = {src_nxt[23:0], b};
        if (p >= ppf_pkg::POS_DST_LO && p <= ppf_pkg::POS_DST_HI)
          dst_nxt = {dst_nxt[23:0], b};
        if (p == h16 + ppf_pkg::OFF_TCP_DO)  tcph_nxt = {b[7:4], 2'b00};
        if (p == h16 + ppf_pkg::OFF_TCP_FLG) ctl_nxt  = (b[2:0] != 3'd0);
        if (p == h16 + ppf_pkg::OFF_PORT_HI) uport_nxt[15:8] = b;
        if (p == h16 + ppf_pkg::OFF_PORT_LO) uport_nxt[7:0]  = b;
        // payload match; the data offset byte never lands on a payload slot
        if (tcph_r >= ppf_pkg::MIN_HDR_BYTES && !start &&
            gm_r < ppf_pkg::MATCH_LEN && p == ps16) begin
          if (ppf_pkg::to_upper(b) == ppf_pkg::get_char(gm_r[1:0]))
            gm_nxt = gm_r + 3'd1;
        end
      end
    end

    cnt = (p == ppf_pkg::IDX_MAX) ? ppf_pkg::IDX_MAX : p + 16'd1;

    if (in_ch.last_byte)               idx_nxt = '0;
    else if (p != ppf_pkg::IDX_MAX)    idx_nxt = p + 16'd1;
    else                               idx_nxt = p;
  end

  // verdict from the updated fields
  ppf_pkg::reason_t rsn;
  logic [15:0]      hn16;
  logic [16:0]      pay_end;

  always_comb begin
    hn16    = {10'd0, ihl_nxt};
    pay_end = {11'd0, ihl_nxt} + {11'd0, tcph_nxt} + {14'd0, ppf_pkg::MATCH_LEN};
    if (!cfg_ready_r || bypass_r)                     rsn = ppf_pkg::RSN_DISABLED;
    else if (!v4_nxt)                                 rsn = ppf_pkg::RSN_NOT_IPV4;
    else if (cnt < ppf_pkg::MIN_PROTO_CNT)            rsn = ppf_pkg::RSN_TRUNC;
    else if (proto_nxt != ppf_pkg::PROTO_TCP && proto_nxt != ppf_pkg::PROTO_UDP &&
             proto_nxt != ppf_pkg::PROTO_ICMP)        rsn = ppf_pkg::RSN_OTHER;
    else if (cnt < ppf_pkg::MIN_HDR_CNT || ihl_nxt < ppf_pkg::MIN_HDR_BYTES)
                                                      rsn = ppf_pkg::RSN_TRUNC;
    else if (ppf_pkg::special_addr(src_nxt) || ppf_pkg::special_addr(dst_nxt))
                                                      rsn = ppf_pkg::RSN_SPECIAL;
    else if (proto_nxt == ppf_pkg::PROTO_TCP) begin
      if (cnt < hn16 + ppf_pkg::OFF_TCP_END)          rsn = ppf_pkg::RSN_TRUNC;
      else if (ctl_nxt)                               rsn = ppf_pkg::RSN_TCP_CTL;
      else if (tcph_nxt < ppf_pkg::MIN_HDR_BYTES)     rsn = ppf_pkg::RSN_TRUNC;
      else if ({1'b0, tlen_nxt} < pay_end)            rsn = ppf_pkg::RSN_NOT_GET;
      else if ({1'b0, cnt} < pay_end)                 rsn = ppf_pkg::RSN_TRUNC;
      else if (gm_nxt < ppf_pkg::MATCH_LEN)           rsn = ppf_pkg::RSN_NOT_GET;
      else                                            rsn = ppf_pkg::RSN_CANDIDATE;
    end else if (proto_nxt == ppf_pkg::PROTO_UDP) begin
      if (cnt < hn16 + ppf_pkg::OFF_UDP_END)          rsn = ppf_pkg::RSN_TRUNC;
      else if (uport_nxt == ppf_pkg::PORT_DNS || uport_nxt == ppf_pkg::PORT_DHCP)
                                                      rsn = ppf_pkg::RSN_DNS_DHCP;
      else                                            rsn = ppf_pkg::RSN_CANDIDATE;
    end else                                          rsn = ppf_pkg::RSN_CANDIDATE;
  end

  // state update on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (in_acc) begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      v4_r    <= v4_nxt;
      ihl_r   <= ihl_nxt;
      tlen_r  <= tlen_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      tcph_r  <= tcph_nxt;
      ctl_r   <= ctl_nxt;
      uport_r <= uport_nxt;
      gm_r    <= gm_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_ch.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_byte) begin
      out_auth_r   <= (rsn == ppf_pkg::RSN_CANDIDATE);
      out_reason_r <= rsn;
    end
  end

  // checks
  a_auth_only_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_auth_r == (out_reason_r == ppf_pkg::RSN_CANDIDATE)))
    else $error("needs_auth disagrees with pass_reason");

  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_byte |=> idx_r == '0)
    else $error("byte position not rewound after last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_byte |=> out_valid_r)
    else $error("last byte produced no verdict");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_valid_r && !out_ch.ready)
    else $error("input stalled without a pending verdict");

  a_gm_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    gm_r <= ppf_pkg::MATCH_LEN || idx_r == '0)
    else $error("payload match count out of range");

endmodule

`default_nettype wire
